// ----- rtl/core/sshd_pkg.sv -----
// ----------------------------------------------------------------------------
// sshd_pkg
// Shared widths, result codes and constants of the SSH packet deframer.
// ----------------------------------------------------------------------------
package sshd_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 18;
  localparam int COUNT_W = 32;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_LEN = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_PAD = 2'd3;

  localparam logic [LEN_W-1:0]   MAX_LEN_RESET   = 18'd35000;
  localparam logic [COUNT_W-1:0] MIN_PACKET_LEN  = 32'd5;
  localparam logic [LEN_W-1:0]   HEADER_OVERHEAD = 18'd2;
  localparam logic [1:0]         LEN_BYTE_LAST   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [COUNT_W-1:0] packet_number;
  } res_t;

endpackage

// ----- rtl/core/sshd_byte_if.sv -----
// ----------------------------------------------------------------------------
// sshd_byte_if
// Valid/ready channel carrying one received link byte per beat.
// ----------------------------------------------------------------------------
interface sshd_byte_if
  import sshd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/sshd_res_if.sv -----
// ----------------------------------------------------------------------------
// sshd_res_if
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface sshd_res_if
  import sshd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data;
  logic               last;
  logic [COUNT_W-1:0] packet_number;

  modport source (output valid, output kind, output data, output last,
                  output packet_number, input ready);
  modport sink   (input valid, input kind, input data, input last,
                  input packet_number, output ready);
endinterface

// ----- rtl/core/ssh_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// ssh_packet_deframer
// Splits a received byte stream into unencrypted SSH binary packets.
// ----------------------------------------------------------------------------
// Takes one link byte per beat on in_ch and gives at most one result per
// byte on out_ch: the message type byte (kind 0) and each payload byte
// (kind 1), the final one of a packet marked with last, a bad length (kind 2,
// raised at the fourth length byte when the length is below 5 or above
// cfg max_packet_len) or a bad padding length (kind 3, raised at the padding
// byte when padding plus 2 exceeds the length). Padding is swallowed. After
// either error every further byte is taken and ignored until reset.
// packet_number counts packets completed before the current one, wrapping at
// 2^32. A byte is taken every clock while in_ch is not stalled: the state
// update is one short step, and results are registered. A two-deep output
// stage (result register plus skid register) keeps in_ch.ready a plain
// register, so in_ch stalls only once two results are waiting on out_ch.
// max_packet_len is read at the fourth length byte of each packet.
// ----------------------------------------------------------------------------
module ssh_packet_deframer
  import sshd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  sshd_byte_if.sink        in_ch,
  sshd_res_if.source       out_ch
);

  // framing phase, one-hot
  typedef enum logic [5:0] {
    PH_LEN     = 6'b000001,
    PH_PAD     = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_PADDING = 6'b010000,
    PH_DEAD    = 6'b100000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   max_len_r;
  logic [COUNT_W-1:0] len_shift_r, len_shift_nxt;
  logic [1:0]         len_idx_r, len_idx_nxt;
  logic [LEN_W-1:0]   payload_left_r, payload_left_nxt;
  logic [BYTE_W-1:0]  padding_left_r, padding_left_nxt;
  logic [COUNT_W-1:0] pkt_count_r, pkt_count_nxt;

  // output stage: result register and skid register
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic               in_acc;
  logic               out_pop;
  logic               push;
  res_t               res;
  logic [COUNT_W-1:0] len_full;
  logic [LEN_W-1:0]   pad_need;
  logic [LEN_W-1:0]   payload_dec;
  logic [BYTE_W-1:0]  padding_dec;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && !skid_valid_r;
  assign out_pop     = out_valid_r && out_ch.ready;

  assign len_full    = {len_shift_r[COUNT_W-BYTE_W-1:0], in_ch.in_byte};
  assign pad_need    = {{(LEN_W-BYTE_W){1'b0}}, in_ch.in_byte} + HEADER_OVERHEAD;
  assign payload_dec = payload_left_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign padding_dec = padding_left_r - {{(BYTE_W-1){1'b0}}, 1'b1};

  // framing step for one accepted byte
  always_comb begin
    phase_nxt        = phase_r;
    len_shift_nxt    = len_shift_r;
    len_idx_nxt      = len_idx_r;
    payload_left_nxt = payload_left_r;
    padding_left_nxt = padding_left_r;
    pkt_count_nxt    = pkt_count_r;
    push             = 1'b0;
    res.kind          = KIND_TYPE;
    res.data          = '0;
    res.last          = 1'b0;
    res.packet_number = pkt_count_r;
    if (in_acc) begin
      case (phase_r)
        PH_LEN: begin
          len_shift_nxt = len_full;
          if (len_idx_r == LEN_BYTE_LAST) begin
            len_idx_nxt = '0;
            if (len_full < MIN_PACKET_LEN ||
                len_full > {{(COUNT_W-LEN_W){1'b0}}, max_len_r}) begin
              push      = 1'b1;
              res.kind  = KIND_BAD_LEN;
              phase_nxt = PH_DEAD;
            end else begin
              phase_nxt = PH_PAD;
            end
          end else begin
            len_idx_nxt = len_idx_r + 2'd1;
          end
        end
        PH_PAD: begin
          // length already bounded by max_packet_len, so 18 bits suffice
          if (pad_need > len_shift_r[LEN_W-1:0]) begin
            push      = 1'b1;
            res.kind  = KIND_BAD_PAD;
            phase_nxt = PH_DEAD;
          end else begin
            payload_left_nxt = len_shift_r[LEN_W-1:0] - pad_need;
            padding_left_nxt = in_ch.in_byte;
            phase_nxt        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          push     = 1'b1;
          res.kind = KIND_TYPE;
          res.data = in_ch.in_byte;
          res.last = (payload_left_r == '0);
          if (payload_left_r == '0) begin
            if (padding_left_r == '0) begin
              pkt_count_nxt = pkt_count_r + 32'd1;
              len_shift_nxt = '0;
              len_idx_nxt   = '0;
              phase_nxt     = PH_LEN;
            end else begin
              phase_nxt = PH_PADDING;
            end
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          payload_left_nxt = payload_dec;
          push             = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.data         = in_ch.in_byte;
          res.last         = (payload_dec == '0);
          if (payload_dec == '0) begin
            if (padding_left_r == '0) begin
              pkt_count_nxt = pkt_count_r + 32'd1;
              len_shift_nxt = '0;
              len_idx_nxt   = '0;
              phase_nxt     = PH_LEN;
            end else begin
              phase_nxt = PH_PADDING;
            end
          end
        end
        PH_PADDING: begin
          padding_left_nxt = padding_dec;
          if (padding_dec == '0) begin
            pkt_count_nxt = pkt_count_r + 32'd1;
            len_shift_nxt = '0;
            len_idx_nxt   = '0;
            phase_nxt     = PH_LEN;
          end
        end
        PH_DEAD: begin
          // swallow everything until reset
          phase_nxt = PH_DEAD;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // framing state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LEN;
      len_shift_r    <= '0;
      len_idx_r      <= '0;
      payload_left_r <= '0;
      padding_left_r <= '0;
      pkt_count_r    <= '0;
      max_len_r      <= MAX_LEN_RESET;
    end else begin
      phase_r        <= phase_nxt;
      len_shift_r    <= len_shift_nxt;
      len_idx_r      <= len_idx_nxt;
      payload_left_r <= payload_left_nxt;
      padding_left_r <= padding_left_nxt;
      pkt_count_r    <= pkt_count_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  // output stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // output stage payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_pop) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.data          = out_r.data;
  assign out_ch.last          = out_r.last;
  assign out_ch.packet_number = out_r.packet_number;

`ifndef SYNTH
  // a skid beat is only ever held behind a waiting result beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the result register is empty");

  // an error result always leaves the block dead
  a_error_kills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (res.kind == KIND_BAD_LEN || res.kind == KIND_BAD_PAD))
      |=> (phase_r == PH_DEAD))
    else $error("error result without entering the dead phase");

  // nothing is produced once dead
  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DEAD) |-> !push)
    else $error("result produced after an error");

  // payload phase always has bytes left to emit
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (payload_left_r != '0))
    else $error("payload phase with no payload left");

  // padding phase always has bytes left to drop
  a_padding_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PADDING) |-> (padding_left_r != '0))
    else $error("padding phase with no padding left");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SSH packet deframer.
// ----------------------------------------------------------------------------
// Drives a byte stream of well-formed packets through several max-length
// settings, with random gaps on the link side and random stalls on the
// result side. Each result beat is checked against a directed expectation
// or an in-bench deframer model. The run ends with one malformed packet,
// which locks the block, and some trailing bytes that must be ignored.
// ----------------------------------------------------------------------------
module testbench;
  import sshd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 1000;  // cycles with no beat on either channel
  localparam int PHASE_BYTES   = 270;
  localparam int NOISE_BYTES   = 20;

  // deframer model phases
  typedef enum logic [2:0] {
    WAIT_LEN, WAIT_PAD, WAIT_TYPE, IN_PAYLOAD, IN_PADDING, LOCKED
  } frame_phase_t;

  // how the run is closed
  typedef enum logic [1:0] {
    TAIL_LONG, TAIL_SHORT, TAIL_PAD, TAIL_LOW_MAX
  } tail_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                typed;
    res_t              want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  sshd_byte_if in_ch ();
  sshd_res_if  out_ch ();

  ssh_packet_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // deframer model state
  frame_phase_t       fp_state;
  logic [31:0]        len_acc;
  logic [1:0]         len_idx;
  logic [LEN_W-1:0]   body_left;
  logic [BYTE_W-1:0]  pad_left;
  logic [COUNT_W-1:0] pkt_count;
  logic [LEN_W-1:0]   max_len;

  res_t              pending_results [$];
  logic [BYTE_W-1:0] frame_bytes [$];

  int  mismatches   = 0;
  int  beats_in     = 0;
  int  beats_out    = 0;
  int  max_writes   = 0;
  int  idle_cycles  = 0;
  int  hold_out     = 0;
  bit  quiet        = 1'b0;

  // directed opening: an empty-payload packet whose padding fills the length,
  // then a minimum-length packet with no padding and extreme payload bytes
  dir_row_t dir_rows [18] = '{
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'hFF, 1'b1, {KIND_TYPE, 8'hFF, 1'b1, 32'd0}},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, {KIND_TYPE, 8'h00, 1'b0, 32'd1}},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h01, 1'b1, {KIND_PAYLOAD, 8'h01, 1'b1, 32'd1}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // deframer model
  // ---------------------------------------------------------------------------

  task automatic close_packet();
    pkt_count = pkt_count + 1;
    len_acc   = '0;
    len_idx   = '0;
    fp_state  = WAIT_LEN;
  endtask

  task automatic end_of_body();
    if (pad_left == '0) close_packet();
    else fp_state = IN_PADDING;
  endtask

  // one link byte in, at most one result out
  task automatic deframe_beat(input logic [BYTE_W-1:0] b, output bit hit, output res_t r);
    hit = 1'b0;
    r   = '0;
    case (fp_state)
      WAIT_LEN: begin
        len_acc = {len_acc[23:0], b};
        if (len_idx == LEN_BYTE_LAST) begin
          len_idx = '0;
          // limit taken as it stands at the fourth length byte
          if (len_acc < MIN_PACKET_LEN || len_acc > 32'(max_len)) begin
            hit      = 1'b1;
            r        = {KIND_BAD_LEN, 8'd0, 1'b0, pkt_count};
            fp_state = LOCKED;
          end else begin
            fp_state = WAIT_PAD;
          end
        end else begin
          len_idx = len_idx + 2'd1;
        end
      end
      WAIT_PAD: begin
        if (32'(b) + 32'(HEADER_OVERHEAD) > len_acc) begin
          hit      = 1'b1;
          r        = {KIND_BAD_PAD, 8'd0, 1'b0, pkt_count};
          fp_state = LOCKED;
        end else begin
          body_left = LEN_W'(len_acc - 32'(HEADER_OVERHEAD) - 32'(b));
          pad_left  = b;
          fp_state  = WAIT_TYPE;
        end
      end
      WAIT_TYPE: begin
        hit = 1'b1;
        r   = {KIND_TYPE, b, body_left == '0, pkt_count};
        if (body_left == '0) end_of_body();
        else fp_state = IN_PAYLOAD;
      end
      IN_PAYLOAD: begin
        body_left = body_left - 18'd1;
        hit       = 1'b1;
        r         = {KIND_PAYLOAD, b, body_left == '0, pkt_count};
        if (body_left == '0) end_of_body();
      end
      IN_PADDING: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == '0) close_packet();
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(20, 4);
  endfunction

  // mostly short packets, some mid-sized, the odd one right at the limit
  function automatic int unsigned pick_len(int unsigned lim);
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(99, 0);
    if (r < 6 && lim <= 700) return lim;
    hi = (r < 16) ? 600 : 40;
    if (hi > lim) hi = lim;
    return $urandom_range(hi, 5);
  endfunction

  function automatic int unsigned pick_pad(int unsigned len);
    int unsigned cap;
    cap = (len - 2 > 255) ? 255 : len - 2;
    if (cap == 255 && $urandom_range(3, 0) == 0) return 255;
    if ($urandom_range(3, 0) == 0) return $urandom_range(cap, 0);
    return $urandom_range((cap < 7) ? cap : 7, 0);
  endfunction

  function automatic void push_len(logic [31:0] len);
    frame_bytes.push_back(len[31:24]);
    frame_bytes.push_back(len[23:16]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
  endfunction

  function automatic void make_packet(int unsigned len, int unsigned pad);
    frame_bytes.delete();
    push_len(len);
    frame_bytes.push_back(BYTE_W'(pad));
    repeat (len - 1 - pad) frame_bytes.push_back(BYTE_W'($urandom_range(255, 0)));
    repeat (pad) frame_bytes.push_back(BYTE_W'($urandom_range(255, 0)));
  endfunction

  // one beat on the link side; the model runs on the accepting edge
  task automatic send_beat(input logic [BYTE_W-1:0] b, input bit typed, input res_t fixed);
    bit   hit;
    res_t r;
    int   gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_in++;
    deframe_beat(b, hit, r);
    if (typed) pending_results.push_back(fixed);
    else if (hit) pending_results.push_back(r);
  endtask

  task automatic send_frame(input int from);
    for (int i = from; i < frame_bytes.size(); i++) send_beat(frame_bytes[i], 1'b0, '0);
  endtask

  // sender holds off until every result is in, then lets the block go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    max_len = v;
    max_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare, watchdog
  // ---------------------------------------------------------------------------

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_out != 0) begin
      out_ch.ready <= 1'b0;
      hold_out--;
    end else begin
      out_ch.ready <= 1'b1;
      hold_out = pick_gap();
    end
  end

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    bit   moved;
    moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: kind %0d data %0h last %0b number %0h",
                 $time, out_ch.kind, out_ch.data, out_ch.last, out_ch.packet_number);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_ch.kind));
        check_field("data", 32'(want.data), 32'(out_ch.data));
        check_field("last", 32'(want.last), 32'(out_ch.last));
        check_field("packet_number", want.packet_number, out_ch.packet_number);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still expected",
               $time, IDLE_LIMIT, pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    logic [LEN_W-1:0] lim;
    int unsigned      len;
    int unsigned      pad;
    int               phase_start;
    tail_t            tail;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = MAX_LEN_RESET;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;

    // model at its reset state
    fp_state  = WAIT_LEN;
    len_acc   = '0;
    len_idx   = '0;
    body_left = '0;
    pad_left  = '0;
    pkt_count = '0;
    max_len   = MAX_LEN_RESET;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening at the reset limit
    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // random packets over a series of limits, smallest and largest among them
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       lim = 18'd5;
        1:       lim = LEN_W'($urandom_range(1000, 6));
        2:       lim = '1;
        3:       lim = LEN_W'($urandom_range(300, 41));
        default: lim = LEN_W'($urandom_range(262143, 5));
      endcase
      quiet = (p == 2);  // one stretch with no idling on either side
      phase_start = beats_in;
      // the limit changes with three length bytes already in; it must still
      // be the new value that the fourth byte is checked against
      len = pick_len(lim);
      make_packet(len, pick_pad(len));
      for (int i = 0; i < 3; i++) send_beat(frame_bytes[i], 1'b0, '0);
      settle();
      write_max(lim);
      send_frame(3);
      while (beats_in - phase_start < PHASE_BYTES) begin
        len = pick_len(lim);
        pad = pick_pad(len);
        make_packet(len, pad);
        send_frame(0);
      end
    end

    // close the run with one malformed packet; the block then stays locked
    quiet = 1'b0;
    tail  = tail_t'($urandom_range(3, 0));
    settle();
    frame_bytes.delete();
    case (tail)
      TAIL_LONG: begin
        if ($urandom_range(1, 0) == 0) push_len(32'(max_len) + 1);
        else push_len($urandom() | 32'h0100_0000);
      end
      TAIL_SHORT: push_len($urandom_range(4, 0));
      TAIL_PAD: begin
        len = $urandom_range((max_len < 256) ? max_len : 256, 5);
        push_len(len);
        frame_bytes.push_back(BYTE_W'($urandom_range(255, len - 1)));
      end
      default: begin
        // limit below the minimum length rejects every packet
        write_max(LEN_W'($urandom_range(4, 0)));
        push_len($urandom_range(40, 5));
      end
    endcase
    repeat (NOISE_BYTES) frame_bytes.push_back(BYTE_W'($urandom_range(255, 0)));
    send_frame(0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("%0d link bytes over %0d limit writes, %0d result beats checked",
             beats_in, max_writes, beats_out);
    $display("%0d packets completed, run closed by %s", pkt_count, tail.name());
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sshd_pkg.sv
rtl/core/sshd_byte_if.sv
rtl/core/sshd_res_if.sv
rtl/core/ssh_packet_deframer.sv
dv/testbench.sv
